// File: rtl/core/pps_pkg.sv
// Shared types, codes and defaults for the preemptive priority scheduler.
package pps_pkg;

  localparam int ENTRIES_DEF = 16;

  typedef logic [7:0]  id_t;
  typedef logic [7:0]  prio_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  status_t;

  // Input opcodes
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result status codes
  localparam status_t ST_RAN    = 2'd0;
  localparam status_t ST_IDLE   = 2'd1;
  localparam status_t ST_ACCEPT = 2'd2;
  localparam status_t ST_REJECT = 2'd3;

  // Running best-candidate record handed from cell to cell
  typedef struct packed {
    logic  sel_found;
    logic  free_found;
    id_t   id;
    prio_t prio;
    word_t burst;
    word_t arrival;
    word_t remaining;
    word_t start;
    logic  started;
  } tok_t;

  // Update broadcast from the controller to the addressed cell
  typedef struct packed {
    logic  alloc;
    logic  run;
    logic  fin;
    id_t   id;
    prio_t prio;
    word_t burst;
    word_t arrival;
    word_t remaining;
    word_t start;
  } upd_t;

endpackage

// File: rtl/core/pps_intf.sv
// Handshake channel interfaces: job input, result output and configuration write.
interface pps_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  pps_pkg::id_t       job_id;
  pps_pkg::prio_t     job_priority;
  pps_pkg::word_t     job_burst;
  modport source (output valid, opcode, job_id, job_priority, job_burst, input ready);
  modport sink   (input valid, opcode, job_id, job_priority, job_burst, output ready);
endinterface

interface pps_out_if;
  logic               valid;
  logic               ready;
  pps_pkg::status_t   status;
  pps_pkg::id_t       run_id;
  logic               finished;
  pps_pkg::word_t     turnaround;
  pps_pkg::word_t     waiting;
  pps_pkg::word_t     response;
  modport source (output valid, status, run_id, finished, turnaround, waiting, response,
                  input ready);
  modport sink   (input valid, status, run_id, finished, turnaround, waiting, response,
                  output ready);
endinterface

interface pps_cfg_if;
  logic valid;
  logic ready;
  logic larger_wins;
  modport source (output valid, larger_wins, input ready);
  modport sink   (input valid, larger_wins, output ready);
endinterface

// File: rtl/core/pps_cell.sv
// One job slot: holds its entry and merges it into the candidate record passing by.
module pps_cell #(
  parameter int ENTRIES  = pps_pkg::ENTRIES_DEF,
  parameter int CELL_IDX = 0,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 larger_wins,
  input  pps_pkg::tok_t        tok_in,
  input  logic [IDX_W-1:0]     sel_idx_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  output pps_pkg::tok_t        tok_out,
  output logic [IDX_W-1:0]     sel_idx_out,
  output logic [IDX_W-1:0]     free_idx_out,
  input  pps_pkg::upd_t        upd,
  input  logic [IDX_W-1:0]     upd_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // Entry storage
  logic           valid_r;
  pps_pkg::id_t   id_r;
  pps_pkg::prio_t prio_r;
  pps_pkg::word_t burst_r;
  pps_pkg::word_t arrival_r;
  pps_pkg::word_t remaining_r;
  pps_pkg::word_t start_r;
  logic           started_r;

  // Chain registers
  pps_pkg::tok_t    tok_r, tok_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic [39:0] key_mine, key_in;
  logic        mine_beats;
  logic        hit;

  // Lexicographic ranking: priority, then original burst, then arrival
  assign key_mine   = {prio_r, burst_r, arrival_r};
  assign key_in     = {tok_in.prio, tok_in.burst, tok_in.arrival};
  assign mine_beats = larger_wins ? (key_mine > key_in) : (key_mine < key_in);

  // Merge own entry into the passing record; ties keep the lower slot
  always_comb begin
    tok_nxt      = tok_in;
    sel_idx_nxt  = sel_idx_in;
    free_idx_nxt = free_idx_in;
    if (valid_r && (!tok_in.sel_found || mine_beats)) begin
      tok_nxt.sel_found = 1'b1;
      tok_nxt.id        = id_r;
      tok_nxt.prio      = prio_r;
      tok_nxt.burst     = burst_r;
      tok_nxt.arrival   = arrival_r;
      tok_nxt.remaining = remaining_r;
      tok_nxt.start     = start_r;
      tok_nxt.started   = started_r;
      sel_idx_nxt       = MY_IDX;
    end
    if (!tok_in.free_found && !valid_r) begin
      tok_nxt.free_found = 1'b1;
      free_idx_nxt       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    sel_idx_r  <= sel_idx_nxt;
    free_idx_r <= free_idx_nxt;
  end

  assign tok_out      = tok_r;
  assign sel_idx_out  = sel_idx_r;
  assign free_idx_out = free_idx_r;

  // Entry update from the controller
  assign hit = (upd_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (hit && upd.alloc) begin
      valid_r <= 1'b1;
    end else if (hit && upd.run && upd.fin) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && upd.alloc) begin
      id_r        <= upd.id;
      prio_r      <= upd.prio;
      burst_r     <= upd.burst;
      arrival_r   <= upd.arrival;
      remaining_r <= upd.burst;
      start_r     <= '0;
      started_r   <= 1'b0;
    end else if (hit && upd.run) begin
      remaining_r <= upd.remaining;
      start_r     <= upd.start;
      started_r   <= 1'b1;
    end
  end

endmodule

// File: rtl/core/pps_ctrl.sv
// Sequencer: takes beats, waits out the selection wave, updates the table and issues results.
module pps_ctrl #(
  parameter int ENTRIES = pps_pkg::ENTRIES_DEF,
  localparam int IDX_W  = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  pps_in_if.sink           in_if,
  pps_out_if.source        out_if,
  pps_cfg_if.sink          cfg_if,
  input  pps_pkg::tok_t    tok_last,
  input  logic [IDX_W-1:0] sel_idx_last,
  input  logic [IDX_W-1:0] free_idx_last,
  output logic             larger_wins,
  output pps_pkg::upd_t    upd,
  output logic [IDX_W-1:0] upd_idx
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  pps_pkg::word_t   time_r, time_nxt;
  logic             larger_wins_r;

  // Latched input beat
  logic           op_r;
  pps_pkg::id_t   id_r;
  pps_pkg::prio_t prio_r;
  pps_pkg::word_t burst_r;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  pps_pkg::status_t status_r, status_nxt;
  pps_pkg::id_t     run_id_r, run_id_nxt;
  logic             fin_r, fin_nxt;
  pps_pkg::word_t   tat_r, tat_nxt;
  pps_pkg::word_t   wait_r, wait_nxt;
  pps_pkg::word_t   resp_r, resp_nxt;

  logic           in_take, apply;
  pps_pkg::word_t rem_dec, start_v, done_t, tat, wt, resp;

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign larger_wins  = larger_wins_r;

  // Result of the wave is final once the counter reaches the row length
  assign apply = (state_r == S_SCAN) && (cnt_r == CNT_W'(ENTRIES))
                 && (!out_valid_r || out_if.ready);

  // Service arithmetic for the selected job
  assign rem_dec = (tok_last.remaining != '0) ? tok_last.remaining - 16'd1 : '0;
  assign start_v = tok_last.started ? tok_last.start : time_r;
  assign done_t  = time_r + 16'd1;
  assign tat     = done_t - tok_last.arrival;
  assign wt      = tat - tok_last.burst;
  assign resp    = start_v - tok_last.arrival;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    time_nxt      = time_r;
    upd           = '0;
    upd_idx       = '0;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    run_id_nxt    = run_id_r;
    fin_nxt       = fin_r;
    tat_nxt       = tat_r;
    wait_nxt      = wait_r;
    resp_nxt      = resp_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_r != CNT_W'(ENTRIES)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (apply) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          fin_nxt       = 1'b0;
          tat_nxt       = '0;
          wait_nxt      = '0;
          resp_nxt      = '0;
          if (op_r == pps_pkg::OP_ARRIVE) begin
            run_id_nxt = id_r;
            if (tok_last.free_found) begin
              status_nxt    = pps_pkg::ST_ACCEPT;
              upd.alloc     = 1'b1;
              upd.id        = id_r;
              upd.prio      = prio_r;
              upd.burst     = burst_r;
              upd.arrival   = time_r;
              upd_idx       = free_idx_last;
            end else begin
              status_nxt = pps_pkg::ST_REJECT;
            end
          end else begin
            time_nxt = done_t;
            if (tok_last.sel_found) begin
              status_nxt    = pps_pkg::ST_RAN;
              run_id_nxt    = tok_last.id;
              upd.run       = 1'b1;
              upd.remaining = rem_dec;
              upd.start     = start_v;
              upd.fin       = (rem_dec == '0);
              upd_idx       = sel_idx_last;
              if (rem_dec == '0) begin
                fin_nxt  = 1'b1;
                tat_nxt  = tat;
                wait_nxt = wt;
                resp_nxt = resp;
              end
            end else begin
              status_nxt = pps_pkg::ST_IDLE;
              run_id_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      time_r        <= '0;
      out_valid_r   <= 1'b0;
      larger_wins_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        larger_wins_r <= cfg_if.larger_wins;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r    <= in_if.opcode;
      id_r    <= in_if.job_id;
      prio_r  <= in_if.job_priority;
      burst_r <= in_if.job_burst;
    end
    status_r <= status_nxt;
    run_id_r <= run_id_nxt;
    fin_r    <= fin_nxt;
    tat_r    <= tat_nxt;
    wait_r   <= wait_nxt;
    resp_r   <= resp_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = status_r;
  assign out_if.run_id     = run_id_r;
  assign out_if.finished   = fin_r;
  assign out_if.turnaround = tat_r;
  assign out_if.waiting    = wait_r;
  assign out_if.response   = resp_r;

endmodule

// File: rtl/core/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler: row of job cells plus sequencer.
//
// Each input beat (job arrival or time tick) is taken while the sequencer is idle; then the
// best-candidate record and the lowest free slot ripple one cell per cycle down the row of
// job cells, after which the table is updated and the result is loaded into the output
// register. The next beat is taken while a result still waits there; a result that is not
// taken holds the following beat's table update until it is. Jobs rank by priority, then
// original burst, then arrival time, larger winning unless the configuration bit is
// cleared; full ties go to the lowest slot.
module preemptive_priority_scheduler_top #(
  parameter int ENTRIES = pps_pkg::ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_if,
  pps_out_if.source out_if,
  pps_cfg_if.sink   cfg_if
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic             larger_wins;
  pps_pkg::upd_t    upd;
  logic [IDX_W-1:0] upd_idx;

  pps_pkg::tok_t    tok     [ENTRIES];
  logic [IDX_W-1:0] sel_idx [ENTRIES];
  logic [IDX_W-1:0] free_idx[ENTRIES];

  // Row of cells; the head sees an empty record
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    pps_pkg::tok_t    tok_in;
    logic [IDX_W-1:0] sel_in;
    logic [IDX_W-1:0] free_in;

    if (k == 0) begin : g_head
      assign tok_in  = '0;
      assign sel_in  = '0;
      assign free_in = '0;
    end else begin : g_link
      assign tok_in  = tok[k-1];
      assign sel_in  = sel_idx[k-1];
      assign free_in = free_idx[k-1];
    end

    pps_cell #(
      .ENTRIES  (ENTRIES),
      .CELL_IDX (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .larger_wins  (larger_wins),
      .tok_in       (tok_in),
      .sel_idx_in   (sel_in),
      .free_idx_in  (free_in),
      .tok_out      (tok[k]),
      .sel_idx_out  (sel_idx[k]),
      .free_idx_out (free_idx[k]),
      .upd          (upd),
      .upd_idx      (upd_idx)
    );
  end

  // Sequencer reads the tail of the row
  pps_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (in_if),
    .out_if        (out_if),
    .cfg_if        (cfg_if),
    .tok_last      (tok[ENTRIES-1]),
    .sel_idx_last  (sel_idx[ENTRIES-1]),
    .free_idx_last (free_idx[ENTRIES-1]),
    .larger_wins   (larger_wins),
    .upd           (upd),
    .upd_idx       (upd_idx)
  );

endmodule

// File: bench/tb_preemptive_priority_scheduler_top.sv
// Self-checking bench for the preemptive priority scheduler top level.
module tb_preemptive_priority_scheduler_top;

  localparam int SLOTS  = pps_pkg::ENTRIES_DEF;
  // One beat walks the whole row of cells; the settle wait before a register write scales with it
  localparam int SETTLE = 4 * (SLOTS + 2);

  typedef struct {
    pps_pkg::status_t status;
    pps_pkg::id_t     run_id;
    logic             finished;
    pps_pkg::word_t   turnaround;
    pps_pkg::word_t   waiting;
    pps_pkg::word_t   response;
  } sched_result_t;

  typedef struct {
    logic           busy;
    pps_pkg::id_t   id;
    pps_pkg::prio_t prio;
    pps_pkg::word_t remaining;
    pps_pkg::word_t burst;
    pps_pkg::word_t arrival;
    pps_pkg::word_t first_run;
    logic           started;
  } job_slot_t;

  logic clk;
  logic rst_n;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();
  pps_cfg_if cfg_ch ();

  preemptive_priority_scheduler_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Scheduler shadow state
  job_slot_t      job_table [SLOTS];
  pps_pkg::word_t sched_time;
  logic           sched_larger_wins;
  sched_result_t  pending_results [$];

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("preemptive_priority_scheduler_top regression: fail");
    $finish;
  end

  // -1: x ranks higher, 1: y ranks higher, 0: equal
  function automatic int key_order(pps_pkg::word_t x, pps_pkg::word_t y);
    if (x == y) return 0;
    if (sched_larger_wins) return (x > y) ? -1 : 1;
    return (x < y) ? -1 : 1;
  endfunction

  // Priority, then original burst, then arrival stamp; strict win only
  function automatic bit outranks(int a, int b);
    int c;
    c = key_order(pps_pkg::word_t'(job_table[a].prio), pps_pkg::word_t'(job_table[b].prio));
    if (c == 0) c = key_order(job_table[a].burst, job_table[b].burst);
    if (c == 0) c = key_order(job_table[a].arrival, job_table[b].arrival);
    return c < 0;
  endfunction

  function automatic int jobs_waiting();
    int n;
    n = 0;
    foreach (job_table[i]) if (job_table[i].busy) n++;
    return n;
  endfunction

  // Apply one beat to the shadow table and return the result it should give
  function automatic sched_result_t predict_schedule(logic op, pps_pkg::id_t id,
                                                     pps_pkg::prio_t prio,
                                                     pps_pkg::word_t burst);
    sched_result_t  r;
    int             slot;
    pps_pkg::word_t tat;
    r    = '{default: '0};
    slot = -1;
    if (op == pps_pkg::OP_ARRIVE) begin
      for (int i = 0; i < SLOTS; i++)
        if (!job_table[i].busy && slot < 0) slot = i;
      r.run_id = id;
      if (slot < 0) begin
        r.status = pps_pkg::ST_REJECT;
      end else begin
        job_table[slot] = '{busy: 1'b1, id: id, prio: prio, remaining: burst, burst: burst,
                            arrival: sched_time, first_run: '0, started: 1'b0};
        r.status = pps_pkg::ST_ACCEPT;
      end
    end else begin
      for (int i = 0; i < SLOTS; i++)
        if (job_table[i].busy && (slot < 0 || outranks(i, slot))) slot = i;
      if (slot < 0) begin
        r.status = pps_pkg::ST_IDLE;
      end else begin
        r.status = pps_pkg::ST_RAN;
        r.run_id = job_table[slot].id;
        if (!job_table[slot].started) begin
          job_table[slot].started   = 1'b1;
          job_table[slot].first_run = sched_time;
        end
        // zero burst finishes on its first run
        if (job_table[slot].remaining != 0)
          job_table[slot].remaining = job_table[slot].remaining - 16'd1;
        if (job_table[slot].remaining == 0) begin
          tat          = sched_time + 16'd1 - job_table[slot].arrival;
          r.finished   = 1'b1;
          r.turnaround = tat;
          r.waiting    = tat - job_table[slot].burst;
          r.response   = job_table[slot].first_run - job_table[slot].arrival;
          job_table[slot].busy = 1'b0;
        end
      end
      sched_time = sched_time + 16'd1;
    end
    return r;
  endfunction

  // Result side: random backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d run_id 0x%0h",
               out_ch.status, out_ch.run_id);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_ch.status));
        check_field("run_id", 16'(want.run_id), 16'(out_ch.run_id));
        check_field("finished", 16'(want.finished), 16'(out_ch.finished));
        check_field("turnaround", want.turnaround, out_ch.turnaround);
        check_field("waiting", want.waiting, out_ch.waiting);
        check_field("response", want.response, out_ch.response);
      end
    end
  end

  // Drivers start and end at a falling edge
  task automatic send_beat(logic op, pps_pkg::id_t id, pps_pkg::prio_t prio,
                           pps_pkg::word_t burst);
    sched_result_t expect_r;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.opcode       = op;
    in_ch.job_id       = id;
    in_ch.job_priority = prio;
    in_ch.job_burst    = burst;
    do @(posedge clk); while (!in_ch.ready);
    expect_r        = predict_schedule(op, id, prio, burst);
    pending_results = {pending_results, expect_r};
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Tick beats carry noise in the job fields
  task automatic send_tick();
    send_beat(pps_pkg::OP_TICK, pps_pkg::id_t'($urandom), pps_pkg::prio_t'($urandom),
              pps_pkg::word_t'($urandom));
  endtask

  task automatic send_arrival(pps_pkg::id_t id, pps_pkg::prio_t prio, pps_pkg::word_t burst);
    send_beat(pps_pkg::OP_ARRIVE, id, prio, burst);
  endtask

  task automatic drain_table();
    while (jobs_waiting() > 0) send_tick();
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write only once the block is quiet
  task automatic set_larger_wins(logic v);
    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid       = 1'b1;
    cfg_ch.larger_wins = v;
    do @(posedge clk); while (!cfg_ch.ready);
    sched_larger_wins = v;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_idling(int s_idle, int r_stall);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
  endtask

  // Tick on an empty table, and a zero-burst job
  task automatic test_idle_and_zero_burst();
    send_tick();
    send_arrival(8'h81, 8'h7E, 16'd0);
    send_tick();
    send_tick();
  endtask

  // Field extremes, full tie to the lowest slot, preemption by a longer burst
  task automatic test_rank_larger();
    send_arrival(8'h00, 8'h00, 16'd1);
    send_arrival(8'hFF, 8'hFF, 16'd2);
    send_arrival(8'h3C, 8'hFF, 16'd2);
    send_tick();
    send_arrival(8'hC3, 8'hFF, 16'd3);
    drain_table();
  endtask

  task automatic test_rank_smaller();
    set_larger_wins(1'b0);
    send_arrival(8'h11, 8'd10, 16'd4);
    send_arrival(8'h22, 8'd10, 16'd2);
    send_arrival(8'h33, 8'd3, 16'd5);
    send_tick();
    // same priority and burst, later stamp: the earlier job keeps the lead
    send_arrival(8'h44, 8'd3, 16'd5);
    drain_table();
    set_larger_wins(1'b1);
  endtask

  // Sixteen jobs fill the table, the seventeenth bounces
  task automatic test_table_full();
    set_idling(29, 29);
    for (int i = 0; i <= SLOTS; i++)
      send_arrival(pps_pkg::id_t'(8'hE0 + i), pps_pkg::prio_t'($urandom_range(0, 3)), 16'd1);
    drain_table();
    set_idling(0, 0);
  endtask

  task automatic run_random_phase(int count, int s_idle, int r_stall, logic lw);
    int             arrive_pct;
    pps_pkg::word_t burst;
    pps_pkg::prio_t prio;
    set_larger_wins(lw);
    set_idling(s_idle, r_stall);
    arrive_pct = 40;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) arrive_pct = $urandom_range(15, 65);
      if ($urandom_range(99) < arrive_pct) begin
        case ($urandom_range(19))
          0:       burst = 16'd0;
          1, 2:    burst = pps_pkg::word_t'($urandom_range(9, 40));
          default: burst = pps_pkg::word_t'($urandom_range(1, 8));
        endcase
        prio = $urandom_range(1) ? pps_pkg::prio_t'($urandom_range(0, 3))
                                 : pps_pkg::prio_t'($urandom);
        send_arrival(pps_pkg::id_t'($urandom), prio, burst);
      end else begin
        send_tick();
      end
    end
  endtask

  task automatic test_random();
    run_random_phase(400, 0, 0, 1'b1);
    run_random_phase(400, 46, 0, 1'b0);
    run_random_phase(400, 0, 46, 1'b1);
    run_random_phase(400, 29, 29, 1'b0);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = pps_pkg::OP_ARRIVE;
    in_ch.job_id       = '0;
    in_ch.job_priority = '0;
    in_ch.job_burst    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.larger_wins = 1'b1;
    mismatches         = 0;
    sched_time         = '0;
    sched_larger_wins  = 1'b1;
    foreach (job_table[i]) job_table[i] = '{default: '0};
    set_idling(0, 0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_and_zero_burst();
    test_rank_larger();
    test_rank_smaller();
    test_table_full();
    test_random();

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("preemptive_priority_scheduler_top regression: pass");
    end else begin
      $display("preemptive_priority_scheduler_top regression: fail");
    end
    $finish;
  end

endmodule
